@@ rtl/wad_pkg.sv @@
`default_nettype none

package wad_pkg;

    // Fixed sizes of the per-cell stores and the payload fields.
    localparam int CELL_BITS    = 16;
    localparam int CELLS        = 65536;
    localparam int HISTORY      = 15;
    localparam int VALUE_BITS   = 10;
    localparam int SLOT_BITS    = 4;
    localparam int HIST_DEPTH   = CELLS * HISTORY;
    localparam int HADDR_BITS   = $clog2(HIST_DEPTH);
    localparam int META_BITS    = 2 * SLOT_BITS;

    // Datapath widths.
    localparam int N_BITS       = 5;
    localparam int SUM_BITS     = 14;
    localparam int SQ_BITS      = 24;
    localparam int SPREAD_BITS  = 29;
    localparam int DIV_BITS     = 37;
    localparam int DEN_BITS     = 8;
    localparam int ROOT_BITS    = 38;
    localparam int MEAN_BITS    = 14;
    localparam int DEV_BITS     = 13;
    localparam int LHS_BITS     = 42;
    localparam int RHS_BITS     = 36;

    // Iteration counts of the shared divider and the square root unit.
    localparam int MEAN_STEPS   = 18;
    localparam int DEV_STEPS    = 37;
    localparam int SQRT_STEPS   = 19;

    // Configuration register indexes and reset values.
    localparam logic [1:0] REG_WINDOW_DAYS = 2'd0;
    localparam logic [1:0] REG_THRESHOLD   = 2'd1;
    localparam logic [3:0] WINDOW_RESET    = 4'd15;
    localparam logic [3:0] THRESH_RESET    = 4'd6;

    localparam logic [DEV_BITS-1:0] DEV_MAX = '1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_META,
        ST_HIST,
        ST_WRITE,
        ST_PREP1,
        ST_PREP2,
        ST_MDIV,
        ST_DDIV,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ rtl/wad_ram.sv @@
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module wad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/window_anomaly_detector.sv @@
`default_nettype none

// Per-cell sliding-window anomaly detector. Each item (cell index, reading) is
// checked against its cell's window of the current reading and up to
// window_days earlier readings, and one result item (mean, sample deviation in
// Q.4, sample count, anomaly flag) is returned for it. Items are processed one
// at a time, through the bit-serial divider (18 steps for the mean, 37 for
// the variance) and the two-bit-per-step square root (19 steps). A reading of
// 0 skips the arithmetic and is returned unchecked. After reset the per-cell
// fill and pointer memory is cleared, one cell per cycle, before the first
// item is accepted; configuration writes are taken throughout. A new item may
// be accepted while the previous result still waits in the output register.
module window_anomaly_detector (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write port.
    input  wire logic                           cfg_wr_en,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [3:0]                     cfg_wdata,
    // Input items.
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [wad_pkg::CELL_BITS-1:0]  s_cell_req,
    input  wire logic [wad_pkg::VALUE_BITS-1:0] s_reading,
    // Result items.
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [wad_pkg::CELL_BITS-1:0]       m_cell_out,
    output logic                                m_checked,
    output logic                                m_anomaly,
    output logic [wad_pkg::MEAN_BITS-1:0]       m_mean_q4,
    output logic [wad_pkg::DEV_BITS-1:0]        m_deviation_q4,
    output logic [wad_pkg::N_BITS-1:0]          m_samples
);

    wad_pkg::state_t state_reg, state_next;

    // Configuration.
    logic [3:0] window_days_reg;
    logic [3:0] threshold_reg;

    // Clearing pass over the metadata memory.
    logic [wad_pkg::CELL_BITS-1:0] clr_cnt_reg;

    // Item context.
    logic [wad_pkg::CELL_BITS-1:0]  cell_reg;
    logic [wad_pkg::VALUE_BITS-1:0] x_reg;
    logic [wad_pkg::SLOT_BITS-1:0]  ptr_reg;
    logic [wad_pkg::SLOT_BITS-1:0]  slot_reg;
    logic [wad_pkg::SLOT_BITS-1:0]  m_cnt_reg;
    logic [wad_pkg::SLOT_BITS-1:0]  rd_cnt_reg;
    logic                           pend_reg;
    logic [wad_pkg::HADDR_BITS-1:0] base_reg;
    logic [wad_pkg::N_BITS-1:0]     n_reg;

    // Window sums and derived terms.
    logic [wad_pkg::SUM_BITS-1:0]    s_reg;
    logic [wad_pkg::SQ_BITS-1:0]     q_reg;
    logic [wad_pkg::SPREAD_BITS-1:0] nq_reg;
    logic [27:0]                     ss_reg;
    logic [14:0]                     nx_reg;
    logic [wad_pkg::DEN_BITS-1:0]    nn1_reg;
    logic [7:0]                      tt_reg;
    logic [wad_pkg::SPREAD_BITS-1:0] spread_reg;
    logic                            gt_reg;
    logic [wad_pkg::SUM_BITS-1:0]    gapd_reg;
    logic [31:0]                     g2_reg;
    logic [12:0]                     ttn_reg;
    logic [wad_pkg::LHS_BITS-1:0]    lhs_reg;
    logic [wad_pkg::RHS_BITS-1:0]    rhs_reg;
    logic [wad_pkg::MEAN_BITS-1:0]   mean_reg;

    // Shared divider.
    logic [wad_pkg::DIV_BITS-1:0] quo_reg;
    logic [wad_pkg::DEN_BITS:0]   rem_reg;
    logic [wad_pkg::DEN_BITS-1:0] den_reg;
    logic [5:0]                   div_cnt_reg;

    // Square root unit.
    logic [wad_pkg::DIV_BITS-1:0]  sq_v_reg;
    logic [wad_pkg::ROOT_BITS-1:0] root_reg;
    logic [wad_pkg::DIV_BITS-1:0]  bit_reg;
    logic [4:0]                    sq_cnt_reg;

    // Output register.
    logic                           m_valid_reg;
    logic [wad_pkg::CELL_BITS-1:0]  m_cell_reg;
    logic                           m_checked_reg;
    logic                           m_anomaly_reg;
    logic [wad_pkg::MEAN_BITS-1:0]  m_mean_reg;
    logic [wad_pkg::DEV_BITS-1:0]   m_dev_reg;
    logic [wad_pkg::N_BITS-1:0]     m_samples_reg;

    // Memory ports.
    logic                           meta_wr_en;
    logic [wad_pkg::CELL_BITS-1:0]  meta_wr_addr;
    logic [wad_pkg::META_BITS-1:0]  meta_wr_data;
    logic                           meta_rd_en;
    logic [wad_pkg::META_BITS-1:0]  meta_rd_data;
    logic                           hist_wr_en;
    logic [wad_pkg::HADDR_BITS-1:0] hist_wr_addr;
    logic                           hist_rd_en;
    logic [wad_pkg::HADDR_BITS-1:0] hist_rd_addr;
    logic [wad_pkg::VALUE_BITS-1:0] hist_rd_data;

    // Combinational helpers.
    logic                           accept;
    logic                           out_free;
    logic [wad_pkg::SLOT_BITS-1:0]  meta_fill;
    logic [wad_pkg::SLOT_BITS-1:0]  meta_ptr;
    logic [wad_pkg::SLOT_BITS-1:0]  fill_new;
    logic [wad_pkg::SLOT_BITS-1:0]  ptr_new;
    logic [wad_pkg::SLOT_BITS-1:0]  wd_clamped;
    logic [wad_pkg::SLOT_BITS-1:0]  m_calc;
    logic [wad_pkg::DEN_BITS:0]     rem_sh;
    logic [wad_pkg::ROOT_BITS-1:0]  sq_trial;
    logic                           done_anomaly;
    logic [wad_pkg::DEV_BITS-1:0]   done_dev;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign meta_fill = meta_rd_data[wad_pkg::META_BITS-1:wad_pkg::SLOT_BITS];
    assign meta_ptr  = meta_rd_data[wad_pkg::SLOT_BITS-1:0];

    // Window length (the stored readings, bounded by window_days), new fill count and ring pointer.
    always_comb begin
        wd_clamped = (window_days_reg > wad_pkg::SLOT_BITS'(wad_pkg::HISTORY))
                   ? wad_pkg::SLOT_BITS'(wad_pkg::HISTORY) : window_days_reg;
        m_calc     = (meta_fill < wd_clamped) ? meta_fill : wd_clamped;
        fill_new   = (meta_fill >= wad_pkg::SLOT_BITS'(wad_pkg::HISTORY))
                   ? wad_pkg::SLOT_BITS'(wad_pkg::HISTORY) : meta_fill + 1'b1;
        ptr_new    = (meta_ptr >= wad_pkg::SLOT_BITS'(wad_pkg::HISTORY - 1))
                   ? '0 : meta_ptr + 1'b1;
    end

    // One restoring division step and one square root step.
    always_comb begin
        rem_sh   = {rem_reg[wad_pkg::DEN_BITS-1:0], quo_reg[wad_pkg::DIV_BITS-1]};
        sq_trial = root_reg + wad_pkg::ROOT_BITS'(bit_reg);
    end

    // Final result terms.
    always_comb begin
        done_anomaly = (n_reg > wad_pkg::N_BITS'(1)) && gt_reg
                     && (lhs_reg < wad_pkg::LHS_BITS'(rhs_reg));
        if (n_reg <= wad_pkg::N_BITS'(1)) begin
            done_dev = '0;
        end else if (root_reg > wad_pkg::ROOT_BITS'(wad_pkg::DEV_MAX)) begin
            done_dev = wad_pkg::DEV_MAX;
        end else begin
            done_dev = root_reg[wad_pkg::DEV_BITS-1:0];
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wad_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == '1) begin
                    state_next = wad_pkg::ST_IDLE;
                end
            end
            wad_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = wad_pkg::ST_META;
                end
            end
            wad_pkg::ST_META: state_next = wad_pkg::ST_HIST;
            wad_pkg::ST_HIST: begin
                if (rd_cnt_reg == m_cnt_reg && !pend_reg) begin
                    state_next = wad_pkg::ST_WRITE;
                end
            end
            wad_pkg::ST_WRITE: begin
                state_next = (x_reg == '0) ? wad_pkg::ST_DONE : wad_pkg::ST_PREP1;
            end
            wad_pkg::ST_PREP1: state_next = wad_pkg::ST_PREP2;
            wad_pkg::ST_PREP2: state_next = wad_pkg::ST_MDIV;
            wad_pkg::ST_MDIV: begin
                if (div_cnt_reg == '0) begin
                    state_next = wad_pkg::ST_DDIV;
                end
            end
            wad_pkg::ST_DDIV: begin
                if (div_cnt_reg == '0) begin
                    state_next = wad_pkg::ST_SQRT;
                end
            end
            wad_pkg::ST_SQRT: begin
                if (sq_cnt_reg == '0) begin
                    state_next = wad_pkg::ST_DONE;
                end
            end
            wad_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = wad_pkg::ST_IDLE;
                end
            end
            default: state_next = wad_pkg::ST_CLEAR;
        endcase
    end

    // Handshake and memory controls.
    always_comb begin
        s_ready      = 1'b0;
        meta_wr_en   = 1'b0;
        meta_wr_addr = cell_reg;
        meta_wr_data = {fill_new, ptr_new};
        meta_rd_en   = 1'b0;
        hist_wr_en   = 1'b0;
        hist_wr_addr = base_reg + wad_pkg::HADDR_BITS'(ptr_reg);
        hist_rd_en   = 1'b0;
        hist_rd_addr = base_reg + wad_pkg::HADDR_BITS'(slot_reg);
        case (state_reg)
            wad_pkg::ST_CLEAR: begin
                meta_wr_en   = 1'b1;
                meta_wr_addr = clr_cnt_reg;
                meta_wr_data = '0;
            end
            wad_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                meta_rd_en = 1'b1;
            end
            wad_pkg::ST_META:  meta_wr_en = 1'b1;
            wad_pkg::ST_HIST:  hist_rd_en = (rd_cnt_reg < m_cnt_reg);
            wad_pkg::ST_WRITE: hist_wr_en = 1'b1;
            default: begin
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_days_reg <= wad_pkg::WINDOW_RESET;
            threshold_reg   <= wad_pkg::THRESH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                wad_pkg::REG_WINDOW_DAYS: window_days_reg <= cfg_wdata;
                wad_pkg::REG_THRESHOLD:   threshold_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wad_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == wad_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            pend_reg <= hist_rd_en;
            if (state_reg == wad_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        case (state_reg)
            wad_pkg::ST_IDLE: begin
                cell_reg <= s_cell_req;
                x_reg    <= s_reading;
            end
            wad_pkg::ST_META: begin
                // The current reading starts the window sums.
                m_cnt_reg  <= (x_reg == '0) ? '0 : m_calc;
                n_reg      <= wad_pkg::N_BITS'(m_calc) + 1'b1;
                ptr_reg    <= meta_ptr;
                slot_reg   <= (meta_ptr == '0) ? wad_pkg::SLOT_BITS'(wad_pkg::HISTORY - 1)
                                               : meta_ptr - 1'b1;
                rd_cnt_reg <= '0;
                base_reg   <= {cell_reg, 4'b0000} - wad_pkg::HADDR_BITS'(cell_reg);
                s_reg      <= wad_pkg::SUM_BITS'(x_reg);
                q_reg      <= wad_pkg::SQ_BITS'(x_reg * x_reg);
            end
            wad_pkg::ST_HIST: begin
                // Walk back through the ring, one entry per cycle.
                if (hist_rd_en) begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    slot_reg   <= (slot_reg == '0)
                                ? wad_pkg::SLOT_BITS'(wad_pkg::HISTORY - 1)
                                : slot_reg - 1'b1;
                end
                if (pend_reg) begin
                    s_reg <= s_reg + wad_pkg::SUM_BITS'(hist_rd_data);
                    q_reg <= q_reg + wad_pkg::SQ_BITS'(hist_rd_data * hist_rd_data);
                end
            end
            wad_pkg::ST_PREP1: begin
                nq_reg  <= wad_pkg::SPREAD_BITS'(n_reg * q_reg);
                ss_reg  <= 28'(s_reg * s_reg);
                nx_reg  <= 15'(n_reg * x_reg);
                nn1_reg <= wad_pkg::DEN_BITS'(n_reg * (n_reg - 1'b1));
                tt_reg  <= 8'(threshold_reg * threshold_reg);
            end
            wad_pkg::ST_PREP2: begin
                // Spread is n*(n-1) times the sample variance.
                spread_reg  <= nq_reg - wad_pkg::SPREAD_BITS'(ss_reg);
                gt_reg      <= (15'(s_reg) > nx_reg);
                gapd_reg    <= wad_pkg::SUM_BITS'(15'(s_reg) - nx_reg);
                quo_reg     <= {s_reg, 4'b0000, 19'b0};
                rem_reg     <= '0;
                den_reg     <= wad_pkg::DEN_BITS'(n_reg);
                div_cnt_reg <= 6'(wad_pkg::MEAN_STEPS);
            end
            wad_pkg::ST_MDIV, wad_pkg::ST_DDIV: begin
                if (state_reg == wad_pkg::ST_MDIV) begin
                    g2_reg  <= {gapd_reg, 2'b00} * {gapd_reg, 2'b00};
                    ttn_reg <= 13'(tt_reg * n_reg);
                end else begin
                    lhs_reg <= wad_pkg::LHS_BITS'(ttn_reg * spread_reg);
                    rhs_reg <= wad_pkg::RHS_BITS'(g2_reg * (n_reg - 1'b1));
                end
                if (div_cnt_reg != '0) begin
                    // Restoring division, one quotient bit per cycle.
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (rem_sh >= {1'b0, den_reg}) begin
                        rem_reg <= rem_sh - {1'b0, den_reg};
                        quo_reg <= {quo_reg[wad_pkg::DIV_BITS-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[wad_pkg::DIV_BITS-2:0], 1'b0};
                    end
                end else if (state_reg == wad_pkg::ST_MDIV) begin
                    mean_reg    <= quo_reg[wad_pkg::MEAN_BITS-1:0];
                    quo_reg     <= {spread_reg, 8'b0};
                    rem_reg     <= '0;
                    den_reg     <= nn1_reg;
                    div_cnt_reg <= 6'(wad_pkg::DEV_STEPS);
                end else begin
                    sq_v_reg   <= quo_reg;
                    root_reg   <= '0;
                    bit_reg    <= {1'b1, {(wad_pkg::DIV_BITS-1){1'b0}}};
                    sq_cnt_reg <= 5'(wad_pkg::SQRT_STEPS);
                end
            end
            wad_pkg::ST_SQRT: begin
                // Digit-by-digit square root, two radicand bits per cycle.
                if (sq_cnt_reg != '0) begin
                    sq_cnt_reg <= sq_cnt_reg - 1'b1;
                    bit_reg    <= bit_reg >> 2;
                    if ({1'b0, sq_v_reg} >= sq_trial) begin
                        sq_v_reg <= sq_v_reg - sq_trial[wad_pkg::DIV_BITS-1:0];
                        root_reg <= (root_reg >> 1) + wad_pkg::ROOT_BITS'(bit_reg);
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (state_reg == wad_pkg::ST_DONE && out_free) begin
            m_cell_reg <= cell_reg;
            if (x_reg == '0) begin
                m_checked_reg <= 1'b0;
                m_anomaly_reg <= 1'b0;
                m_mean_reg    <= '0;
                m_dev_reg     <= '0;
                m_samples_reg <= '0;
            end else begin
                m_checked_reg <= 1'b1;
                m_anomaly_reg <= done_anomaly;
                m_mean_reg    <= mean_reg;
                m_dev_reg     <= done_dev;
                m_samples_reg <= n_reg;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_cell_out     = m_cell_reg;
    assign m_checked      = m_checked_reg;
    assign m_anomaly      = m_anomaly_reg;
    assign m_mean_q4      = m_mean_reg;
    assign m_deviation_q4 = m_dev_reg;
    assign m_samples      = m_samples_reg;

    // Per-cell fill count and ring pointer.
    wad_ram #(
        .WIDTH (wad_pkg::META_BITS),
        .DEPTH (wad_pkg::CELLS)
    ) u_meta_ram (
        .aclk    (aclk),
        .wr_en   (meta_wr_en),
        .wr_addr (meta_wr_addr),
        .wr_data (meta_wr_data),
        .rd_en   (meta_rd_en),
        .rd_addr (s_cell_req),
        .rd_data (meta_rd_data)
    );

    // Per-cell ring of earlier readings.
    wad_ram #(
        .WIDTH (wad_pkg::VALUE_BITS),
        .DEPTH (wad_pkg::HIST_DEPTH)
    ) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (hist_wr_en),
        .wr_addr (hist_wr_addr),
        .wr_data (x_reg),
        .rd_en   (hist_rd_en),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_rd_data)
    );

`ifndef ASSERT_OFF
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == wad_pkg::ST_CLEAR |-> !s_ready)
        else $error("item accepted during clearing pass");
    a_unchecked_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_checked |-> !m_anomaly && m_samples == '0)
        else $error("unchecked item carries results");
    a_sample_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_checked |-> m_samples >= 5'd1 && m_samples <= 5'd16)
        else $error("sample count out of range");
    a_single_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_samples == 5'd1 |-> m_deviation_q4 == '0 && !m_anomaly)
        else $error("single sample gives deviation or anomaly");
`endif

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 300000;
    localparam int SETTLE      = 200;

    typedef struct packed {
        logic [wad_pkg::CELL_BITS-1:0]  cell_id;
        logic                           checked;
        logic                           anomaly;
        logic [wad_pkg::MEAN_BITS-1:0]  mean;
        logic [wad_pkg::DEV_BITS-1:0]   dev;
        logic [wad_pkg::N_BITS-1:0]     samples;
    } verdict_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [1:0]                     cfg_index = '0;
    logic [3:0]                     cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [wad_pkg::CELL_BITS-1:0]  s_cell_req = '0;
    logic [wad_pkg::VALUE_BITS-1:0] s_reading = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [wad_pkg::CELL_BITS-1:0]  m_cell_out;
    logic                           m_checked;
    logic                           m_anomaly;
    logic [wad_pkg::MEAN_BITS-1:0]  m_mean_q4;
    logic [wad_pkg::DEV_BITS-1:0]   m_deviation_q4;
    logic [wad_pkg::N_BITS-1:0]     m_samples;

    // Predictor copy of the configuration and the per-cell stores.
    logic [3:0]                     days_cfg = wad_pkg::WINDOW_RESET;
    logic [3:0]                     thresh_cfg = wad_pkg::THRESH_RESET;
    logic [wad_pkg::VALUE_BITS-1:0] ring_mem [int];
    int unsigned                    fill_mem [int];
    int unsigned                    ptr_mem  [int];

    verdict_t              pending_verdicts [$];
    int                    errors = 0;
    int                    items_sent = 0;
    int                    results_seen = 0;
    int                    anomalies_seen = 0;
    int                    idle_count = 0;
    bit                    no_idle = 1'b0;

    window_anomaly_detector dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_cell_req(s_cell_req), .s_reading(s_reading),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_cell_out(m_cell_out), .m_checked(m_checked), .m_anomaly(m_anomaly),
        .m_mean_q4(m_mean_q4), .m_deviation_q4(m_deviation_q4), .m_samples(m_samples)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Computes the window statistics for one reading and pushes it into the ring.
    function automatic verdict_t score_reading(logic [wad_pkg::CELL_BITS-1:0] cell_id,
                                               logic [wad_pkg::VALUE_BITS-1:0] x);
        verdict_t v;
        int unsigned fill, ptr, wd, m, slot, key;
        longint unsigned n, s, q, h, spread, d, dv, gap, t;
        key  = cell_id;
        fill = fill_mem.exists(key) ? fill_mem[key] : 0;
        ptr  = ptr_mem.exists(key) ? ptr_mem[key] : 0;
        v = '0;
        v.cell_id = cell_id;
        if (x != 0) begin
            wd = (days_cfg > wad_pkg::HISTORY) ? wad_pkg::HISTORY : days_cfg;
            m  = (fill < wd) ? fill : wd;
            n  = m + 1;
            s  = x;
            q  = longint'(x) * x;
            for (int i = 0; i < m; i++) begin
                slot = (ptr + wad_pkg::HISTORY - 1 - i) % wad_pkg::HISTORY;
                h = ring_mem[key * wad_pkg::HISTORY + slot];
                s += h;
                q += h * h;
            end
            v.checked = 1'b1;
            v.samples = wad_pkg::N_BITS'(n);
            v.mean = wad_pkg::MEAN_BITS'((16 * s) / n);
            if (n > 1) begin
                spread = n * q - s * s;
                d  = (256 * spread) / (n * (n - 1));
                dv = int_sqrt(d);
                v.dev = (dv > wad_pkg::DEV_MAX) ? wad_pkg::DEV_MAX : wad_pkg::DEV_BITS'(dv);
                if (s > n * x) begin
                    gap = 4 * (s - n * x);
                    t = thresh_cfg;
                    v.anomaly = (t * t * n * spread < gap * gap * (n - 1));
                end
            end
        end
        if (fill < wad_pkg::HISTORY) fill++;
        ring_mem[key * wad_pkg::HISTORY + ptr] = x;
        fill_mem[key] = fill;
        ptr_mem[key]  = (ptr + 1) % wad_pkg::HISTORY;
        return v;
    endfunction

    // Sends one item; afterwards valid may drop at random for a gap, unless no_idle is set.
    task automatic send_item(logic [wad_pkg::CELL_BITS-1:0] cell_id,
                             logic [wad_pkg::VALUE_BITS-1:0] x);
        s_valid    <= 1'b1;
        s_cell_req <= cell_id;
        s_reading  <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_verdicts.push_back(score_reading(cell_id, x));
        items_sent++;
        if (!no_idle && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    // Register writes happen only once the block has nothing in flight.
    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        wait_results();
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == wad_pkg::REG_WINDOW_DAYS) days_cfg = val;
        else if (idx == wad_pkg::REG_THRESHOLD) thresh_cfg = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_directed();
        // Single samples at the extremes, a missing reading, and an unfilled window.
        send_item(16'd0, 10'd1023);
        send_item(16'd0, 10'd0);
        send_item(16'hFFFF, 10'd1);
        send_item(16'hFFFF, 10'd1023);
        // Large spread saturates the deviation.
        send_item(16'd7, 10'd0);
        send_item(16'd7, 10'd1023);
        // A steady cell followed by a sharp drop.
        for (int i = 0; i < 8; i++) send_item(16'd9, 10'd500 + 10'(i % 2));
        send_item(16'd9, 10'd1);
        // Ignored writes to unused register indexes.
        write_reg(2'd2, 4'hF);
        write_reg(2'd3, 4'h0);
        send_item(16'd9, 10'd2);
        // Window of the current reading alone, then a one-reading window with threshold 0, then the widest threshold.
        write_reg(wad_pkg::REG_WINDOW_DAYS, 4'd0);
        send_item(16'd9, 10'd3);
        write_reg(wad_pkg::REG_WINDOW_DAYS, 4'd1);
        write_reg(wad_pkg::REG_THRESHOLD, 4'd0);
        send_item(16'd9, 10'd4);
        send_item(16'd9, 10'd5);
        write_reg(wad_pkg::REG_THRESHOLD, 4'd15);
        write_reg(wad_pkg::REG_WINDOW_DAYS, 4'd15);
        send_item(16'd9, 10'd1);
        send_item(16'h8000, 10'h2AA);
        send_item(16'h8000, 10'h155);
        wait_results();
    endtask

    task automatic test_random_phases();
        logic [wad_pkg::CELL_BITS-1:0]  hot_cells [6];
        int unsigned                    base [6];
        int unsigned                    days_set [6] = '{15, 0, 1, 7, 15, 3};
        int unsigned                    thr_set [6]  = '{6, 15, 0, 4, 15, 9};
        int                             k, r;
        logic [wad_pkg::CELL_BITS-1:0]  cell_id;
        logic [wad_pkg::VALUE_BITS-1:0] x;
        for (int i = 0; i < 6; i++) begin
            hot_cells[i] = wad_pkg::CELL_BITS'($urandom);
            base[i] = $urandom_range(1000, 40);
        end
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(wad_pkg::REG_WINDOW_DAYS,
                      (ph == 5) ? 4'($urandom) : 4'(days_set[ph]));
            write_reg(wad_pkg::REG_THRESHOLD,
                      (ph == 5) ? 4'($urandom) : 4'(thr_set[ph]));
            no_idle = (ph == 3);
            for (int i = 0; i < 240; i++) begin
                k = $urandom_range(5);
                r = $urandom_range(99);
                cell_id = (r < 85) ? hot_cells[k] : 16'($urandom);
                r = $urandom_range(99);
                if (r < 8) x = '0;
                else if (r < 18) x = wad_pkg::VALUE_BITS'($urandom_range(1023, 1));
                else if (r < 28) x = wad_pkg::VALUE_BITS'($urandom_range(base[k] / 3 + 1, 1));
                else x = wad_pkg::VALUE_BITS'($urandom_range(base[k] + 25, base[k] - 25));
                send_item(cell_id, x);
                // Let the block drain completely every so often.
                if (i % 100 == 99) wait_results();
            end
            no_idle = 1'b0;
        end
        wait_results();
    endtask

    // Result side: random backpressure (none while no_idle is set) and the field-by-field check.
    always @(posedge aclk) begin
        verdict_t exp_v;
        m_ready <= no_idle || ($urandom_range(99) >= 24);
        if (m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result item with nothing expected, cell %0d", m_cell_out);
                errors++;
            end else begin
                exp_v = pending_verdicts.pop_front();
                results_seen++;
                if (m_anomaly) anomalies_seen++;
                if (m_cell_out !== exp_v.cell_id) begin
                    $error("cell_out expected %0d got %0d", exp_v.cell_id, m_cell_out);
                    errors++;
                end
                if (m_checked !== exp_v.checked) begin
                    $error("checked expected %0d got %0d", exp_v.checked, m_checked);
                    errors++;
                end
                if (m_anomaly !== exp_v.anomaly) begin
                    $error("anomaly expected %0d got %0d", exp_v.anomaly, m_anomaly);
                    errors++;
                end
                if (m_mean_q4 !== exp_v.mean) begin
                    $error("mean_q4 expected %0d got %0d", exp_v.mean, m_mean_q4);
                    errors++;
                end
                if (m_deviation_q4 !== exp_v.dev) begin
                    $error("deviation_q4 expected %0d got %0d", exp_v.dev, m_deviation_q4);
                    errors++;
                end
                if (m_samples !== exp_v.samples) begin
                    $error("samples expected %0d got %0d", exp_v.samples, m_samples);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item or result.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_phases();
        repeat (SETTLE) @(posedge aclk);
        if (pending_verdicts.size() != 0) begin
            $error("%0d expected results never arrived", pending_verdicts.size());
            errors++;
        end
        $display("Sent %0d items over six register settings; %0d results, %0d anomalies.",
                 items_sent, results_seen, anomalies_seen);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/wad_pkg.sv
rtl/wad_ram.sv
rtl/window_anomaly_detector.sv
sim/testbench.sv
